FILE: src/swt_pkg.sv
// Shared constants, types and the CORDIC arctangent table of the spiral warp address generator.
`default_nettype none

package swt_pkg;

   localparam int MAX_DIM  = 4096;
   localparam int PI_Q16   = 205887;
   localparam int INVK_Q16 = 39798;

   localparam int XW   = 12;    // destination coordinate
   localparam int DW   = 13;    // frame dimension
   localparam int TW   = 17;    // progress, Q1.16
   localparam int ZW   = 20;    // angle, Q16 radians
   localparam int VW   = 32;    // vectoring datapath
   localparam int RW   = 30;    // radius, Q16 pixels
   localparam int BRW  = 38;    // radius after radial growth
   localparam int AW   = 38;    // angle sum before wrapping
   localparam int MODK = 19;    // conditional subtract steps of the wrap
   localparam int RVW  = 40;    // rotation datapath
   localparam int OW   = RVW + 1;
   localparam int PXW  = 16;    // source coordinate
   localparam int IDXW = 24;

   localparam int CSR_IW = 2;
   localparam int CSR_DW = 17;
   localparam logic [CSR_IW-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_PROGRESS     = 2'd2;

   typedef logic [DW-1:0]          dim_type;
   typedef logic [RW-1:0]          rad_type;
   typedef logic signed [ZW-1:0]   ang_type;
   typedef logic [BRW-1:0]         big_type;
   typedef logic signed [OW-1:0]   coord_type;

   localparam ang_type PI_ANG   = ang_type'(PI_Q16);
   localparam ang_type HALF_ANG = ang_type'(PI_Q16 / 2);
   localparam ang_type M_ANG    = ang_type'(2 * PI_Q16);

   // atan(2^-i) in Q16
   function automatic ang_type atan_entry(input int i);
      ang_type v;
      case (i)
         0: v = ang_type'(51472);
         1: v = ang_type'(30386);
         2: v = ang_type'(16055);
         3: v = ang_type'(8150);
         4: v = ang_type'(4091);
         5: v = ang_type'(2047);
         6: v = ang_type'(1024);
         7: v = ang_type'(512);
         8: v = ang_type'(256);
         default: v = ang_type'(32'd65536 >> i);
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: src/spiral_twist_warp_address.sv
// Top level of the spiral warp address generator: registers, pipeline chain, output stage.
// Throughput: one transfer per cycle; every stage is a register slice moving on one enable.
// The 30-stage width divider and the two CORDIC pipelines set the depth.
// A stalled result freezes the whole pipe; the input takes a transfer in any other cycle.
// Reset (synchronous) empties the pipe and loads width 1024, height 1024, progress 0.
`default_nettype none

module spiral_twist_warp_address #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [swt_pkg::XW-1:0]         req_dest_x,
   input  logic [swt_pkg::XW-1:0]         req_dest_y,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [swt_pkg::PXW-1:0] rsp_source_x,
   output logic signed [swt_pkg::PXW-1:0] rsp_source_y,
   output logic                           rsp_outside,
   output logic [swt_pkg::IDXW-1:0]       rsp_source_index,
   // register writes
   input  logic                           csr_write,
   input  logic [swt_pkg::CSR_IW-1:0]     csr_index,
   input  logic [swt_pkg::CSR_DW-1:0]     csr_wdata
);
   import swt_pkg::*;

   localparam int CW = OW + 2;

   // registers
   dim_type         width_ff, height_ff;
   logic [TW-1:0]   progress_ff;
   dim_type         w_cl, h_cl;

   // global advance: the pipe moves unless a finished result is held back
   logic            en;

   logic            vec_vld, div_vld, ang_vld, rot_vld;
   rad_type         vec_r, div_r, div_ratio;
   ang_type         vec_z, div_z, ang_angle;
   big_type         ang_big;
   logic            ang_flip, rot_flip;
   coord_type       rot_x, rot_y;

   // output stages
   logic signed [OW:0]      fx, fy;
   logic signed [CW-1:0]    cx_in, cy_in, cx_ff, cy_ff;
   logic                    c_vld_ff;
   logic signed [PXW-1:0]   sx_in, sy_in, sx_ff, sy_ff;
   logic                    out_in;
   logic                    out_ff;
   logic                    p_vld_ff;
   logic [IDXW:0]           idx_in;

   logic                    rsp_valid_ff;
   logic signed [PXW-1:0]   rsp_x_ff, rsp_y_ff;
   logic                    rsp_out_ff;
   logic [IDXW-1:0]         rsp_idx_ff;

   // truncate Q16 toward zero to whole pixels, saturate to 16 bit signed
   function automatic logic signed [PXW-1:0] to_pixel(input logic signed [CW-1:0] q);
      logic [CW-1:0]          mag;
      logic signed [CW-1:0]   p;
      logic signed [PXW-1:0]  res;
      mag = q[CW-1] ? CW'(-q) : CW'(q);
      p   = $signed(mag >> 16);
      if (q[CW-1]) p = -p;
      if (p > CW'(32767))
         res = 16'sh7fff;
      else if (p < -CW'(32768))
         res = 16'sh8000;
      else
         res = p[PXW-1:0];
      return res;
   endfunction

   //----------------------------------------------------------------
   // register file
   //----------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= DW'(1024);
         height_ff   <= DW'(1024);
         progress_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_ff    <= csr_wdata[DW-1:0];
            CSR_FRAME_HEIGHT: height_ff   <= csr_wdata[DW-1:0];
            CSR_PROGRESS:     progress_ff <= csr_wdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // zero dimension reads as 1, oversize as the maximum
   always_comb begin
      w_cl = (width_ff == '0) ? DW'(1) :
             (width_ff > DW'(MAX_DIM)) ? DW'(MAX_DIM) : width_ff;
      h_cl = (height_ff == '0) ? DW'(1) :
             (height_ff > DW'(MAX_DIM)) ? DW'(MAX_DIM) : height_ff;
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   //----------------------------------------------------------------
   // pipeline chain
   //----------------------------------------------------------------
   swt_cordic_vec #(.STEPS(CORDIC_STEPS)) u_vec (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_valid),
      .dest_x  (req_dest_x),
      .dest_y  (req_dest_y),
      .width   (w_cl),
      .height  (h_cl),
      .out_vld (vec_vld),
      .out_r   (vec_r),
      .out_z   (vec_z)
   );

   swt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (vec_vld),
      .in_r      (vec_r),
      .in_z      (vec_z),
      .width     (w_cl),
      .out_vld   (div_vld),
      .out_ratio (div_ratio),
      .out_r     (div_r),
      .out_z     (div_z)
   );

   swt_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (div_vld),
      .in_r      (div_r),
      .in_ratio  (div_ratio),
      .in_z      (div_z),
      .progress  (progress_ff),
      .out_vld   (ang_vld),
      .out_big_r (ang_big),
      .out_angle (ang_angle),
      .out_flip  (ang_flip)
   );

   swt_cordic_rot #(.STEPS(CORDIC_STEPS)) u_rot (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (ang_vld),
      .in_big_r (ang_big),
      .in_angle (ang_angle),
      .in_flip  (ang_flip),
      .out_vld  (rot_vld),
      .out_x    (rot_x),
      .out_y    (rot_y),
      .out_flip (rot_flip)
   );

   //----------------------------------------------------------------
   // back to frame coordinates
   //----------------------------------------------------------------
   // undo the half-turn fold, add the centre in Q16
   always_comb begin
      fx    = rot_flip ? -(OW+1)'(rot_x) : (OW+1)'(rot_x);
      fy    = rot_flip ? -(OW+1)'(rot_y) : (OW+1)'(rot_y);
      cx_in = CW'(fx) + CW'($signed({1'b0, w_cl, 15'b0}));
      cy_in = CW'(fy) + CW'($signed({1'b0, h_cl, 15'b0}));
   end

   // whole pixels and frame check
   always_comb begin
      sx_in  = to_pixel(cx_ff);
      sy_in  = to_pixel(cy_ff);
      out_in = sx_in[PXW-1] || sy_in[PXW-1] ||
               (sx_in[PXW-2:0] >= (PXW-1)'(w_cl)) ||
               (sy_in[PXW-2:0] >= (PXW-1)'(h_cl));
   end

   // raster index; coordinates are inside the frame when it is used
   always_comb begin
      idx_in = (IDXW+1)'(sy_ff[XW-1:0]) * (IDXW+1)'(w_cl) + (IDXW+1)'(sx_ff[XW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff     <= rot_vld;
         p_vld_ff     <= c_vld_ff;
         rsp_valid_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         out_ff     <= out_in;
         rsp_x_ff   <= sx_ff;
         rsp_y_ff   <= sy_ff;
         rsp_out_ff <= out_ff;
         rsp_idx_ff <= out_ff ? '0 : idx_in[IDXW-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_source_x     = rsp_x_ff;
   assign rsp_source_y     = rsp_y_ff;
   assign rsp_outside      = rsp_out_ff;
   assign rsp_source_index = rsp_idx_ff;

   //----------------------------------------------------------------
   // checks
   //----------------------------------------------------------------
   a_outside_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outside |-> rsp_source_index == '0)
      else $error("index not cleared for a source outside the frame");

   a_inside_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_outside |->
         !rsp_source_x[PXW-1] && !rsp_source_y[PXW-1] &&
         (rsp_source_x[PXW-2:0] < (PXW-1)'(w_cl)) &&
         (rsp_source_y[PXW-2:0] < (PXW-1)'(h_cl)))
      else $error("source flagged inside but lies off the frame");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(rot_vld) && $stable(p_vld_ff))
      else $error("pipe moved while the result was held");

endmodule

`default_nettype wire

FILE: src/swt_cordic_vec.sv
// Vectoring CORDIC pipeline: destination offset to polar radius and angle.
`default_nettype none

module swt_cordic_vec #(
   parameter int STEPS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_vld,
   input  logic [swt_pkg::XW-1:0]    dest_x,
   input  logic [swt_pkg::XW-1:0]    dest_y,
   input  swt_pkg::dim_type          width,
   input  swt_pkg::dim_type          height,
   output logic                      out_vld,
   output swt_pkg::rad_type          out_r,
   output swt_pkg::ang_type          out_z
);
   import swt_pkg::*;

   localparam int PW = VW + 17;

   logic signed [DW:0]    dx, dy;
   logic signed [VW-1:0]  ox0, oy0, vx0, vy0;
   ang_type               z0;

   logic signed [VW-1:0]  vx_ff [0:STEPS];
   logic signed [VW-1:0]  vy_ff [0:STEPS];
   ang_type               z_ff  [0:STEPS];
   logic                  vld_ff [0:STEPS];
   logic signed [VW-1:0]  vx_in [1:STEPS];
   logic signed [VW-1:0]  vy_in [1:STEPS];
   ang_type               z_in  [1:STEPS];

   logic signed [PW-1:0]  prod;
   logic signed [PW-1:0]  r_full;
   rad_type               r_in;
   rad_type               r_ff;
   ang_type               zo_ff;
   logic                  vo_ff;

   // offsets with one fraction bit, moved to Q16
   assign dx = $signed({1'b0, dest_x, 1'b0}) - $signed({1'b0, width});
   assign dy = $signed({1'b0, dest_y, 1'b0}) - $signed({1'b0, height});

   always_comb begin
      ox0 = VW'(dx) <<< 15;
      oy0 = VW'(dy) <<< 15;
      vx0 = ox0;
      vy0 = oy0;
      z0  = '0;
      if (ox0[VW-1]) begin
         z0  = oy0[VW-1] ? -PI_ANG : PI_ANG;
         vx0 = -ox0;
         vy0 = -oy0;
      end
   end

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         if (!vy_ff[k][VW-1]) begin
            vx_in[k+1] = vx_ff[k] + (vy_ff[k] >>> k);
            vy_in[k+1] = vy_ff[k] - (vx_ff[k] >>> k);
            z_in[k+1]  = z_ff[k] + atan_entry(k);
         end else begin
            vx_in[k+1] = vx_ff[k] - (vy_ff[k] >>> k);
            vy_in[k+1] = vy_ff[k] + (vx_ff[k] >>> k);
            z_in[k+1]  = z_ff[k] - atan_entry(k);
         end
      end
   end

   // gain correction
   always_comb begin
      prod   = PW'(vx_ff[STEPS]) * PW'(INVK_Q16);
      r_full = prod >>> 16;
      r_in   = r_full[PW-1] ? '0 : r_full[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= STEPS; k++) vld_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int k = 0; k < STEPS; k++) vld_ff[k+1] <= vld_ff[k];
         vo_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0] <= vx0;
         vy_ff[0] <= vy0;
         z_ff[0]  <= z0;
         for (int k = 0; k < STEPS; k++) begin
            vx_ff[k+1] <= vx_in[k+1];
            vy_ff[k+1] <= vy_in[k+1];
            z_ff[k+1]  <= z_in[k+1];
         end
         r_ff  <= r_in;
         zo_ff <= z_ff[STEPS];
      end
   end

   assign out_vld = vo_ff;
   assign out_r   = r_ff;
   assign out_z   = zo_ff;

endmodule

`default_nettype wire

FILE: src/swt_div.sv
// Radix-2 restoring divider pipeline: radius over frame width, one quotient bit per stage.
`default_nettype none

module swt_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_vld,
   input  swt_pkg::rad_type   in_r,
   input  swt_pkg::ang_type   in_z,
   input  swt_pkg::dim_type   width,
   output logic               out_vld,
   output swt_pkg::rad_type   out_ratio,
   output swt_pkg::rad_type   out_r,
   output swt_pkg::ang_type   out_z
);
   import swt_pkg::*;

   rad_type          num_ff [1:RW];
   dim_type          rem_ff [1:RW];
   rad_type          quo_ff [1:RW];
   ang_type          z_ff   [1:RW];
   logic             vld_ff [1:RW];
   // stage views, stage 0 being the input itself
   rad_type          num_s  [0:RW-1];
   dim_type          rem_s  [0:RW-1];
   rad_type          quo_s  [0:RW-1];
   ang_type          z_s    [0:RW-1];
   logic             vld_s  [0:RW-1];
   dim_type          rem_in [1:RW];
   rad_type          quo_in [1:RW];
   logic [DW:0]      trial;
   logic             ge;

   always_comb begin
      num_s[0] = in_r;
      rem_s[0] = '0;
      quo_s[0] = '0;
      z_s[0]   = in_z;
      vld_s[0] = in_vld;
      for (int j = 1; j < RW; j++) begin
         num_s[j] = num_ff[j];
         rem_s[j] = rem_ff[j];
         quo_s[j] = quo_ff[j];
         z_s[j]   = z_ff[j];
         vld_s[j] = vld_ff[j];
      end
   end

   always_comb begin
      trial = '0;
      ge    = 1'b0;
      for (int j = 0; j < RW; j++) begin
         trial = {rem_s[j], num_s[j][RW-1-j]};
         ge    = (trial >= {1'b0, width});
         rem_in[j+1] = ge ? DW'(trial - {1'b0, width}) : trial[DW-1:0];
         quo_in[j+1] = quo_s[j] | (RW'(ge) << (RW-1-j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 1; j <= RW; j++) vld_ff[j] <= 1'b0;
      end else if (en) begin
         for (int j = 0; j < RW; j++) vld_ff[j+1] <= vld_s[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < RW; j++) begin
            num_ff[j+1] <= num_s[j];
            rem_ff[j+1] <= rem_in[j+1];
            quo_ff[j+1] <= quo_in[j+1];
            z_ff[j+1]   <= z_s[j];
         end
      end
   end

   assign out_vld   = vld_ff[RW];
   assign out_ratio = quo_ff[RW];
   assign out_r     = num_ff[RW];
   assign out_z     = z_ff[RW];

endmodule

`default_nettype wire

FILE: src/swt_angle.sv
// Radial growth, twist angle and wrap of the angle into [-pi/2, pi/2] with a flip flag.
`default_nettype none

module swt_angle (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_vld,
   input  swt_pkg::rad_type        in_r,
   input  swt_pkg::rad_type        in_ratio,
   input  swt_pkg::ang_type        in_z,
   input  logic [swt_pkg::TW-1:0]  progress,
   output logic                    out_vld,
   output swt_pkg::big_type        out_big_r,
   output swt_pkg::ang_type        out_angle,
   output logic                    out_flip
);
   import swt_pkg::*;

   localparam int PRW = TW + RW;
   localparam int TRW = PRW - 16;
   localparam int TWW = TRW + 18;

   // stage A
   logic [PRW-1:0]  prod_ff;
   rad_type         ra_ff;
   ang_type         za_ff;
   logic            va_ff;
   // stage B
   logic [PRW+5:0]  p60;
   big_type         big_in, bigb_ff;
   logic [TWW-1:0]  tw_in, twb_ff;
   ang_type         zb_ff;
   logic            vb_ff;
   // stage C and wrap
   logic [AW-1:0]   sum_in;
   logic [AW-1:0]   m_ff   [0:MODK];
   big_type         big_ff [0:MODK];
   logic            vld_ff [0:MODK];
   logic [AW-1:0]   m_in   [1:MODK];
   logic [AW-1:0]   sub;
   // fold
   ang_type         a0, a1, a_in;
   logic            flip_in;
   ang_type         a_ff;
   logic            flip_ff;
   big_type         bo_ff;
   logic            vo_ff;

   always_comb begin
      p60    = (PRW+6)'(prod_ff) * (PRW+6)'(60);
      big_in = BRW'(ra_ff) + BRW'(p60[PRW+5:16]);
      tw_in  = TWW'(prod_ff[PRW-1:16]) * TWW'(PI_Q16);
      // offset of two turns keeps the sum non-negative
      sum_in = AW'(twb_ff[TWW-1:14]) + AW'(zb_ff) + AW'(4 * PI_Q16);
   end

   always_comb begin
      sub = '0;
      for (int j = 0; j < MODK; j++) begin
         sub = AW'(2 * PI_Q16) << (MODK-1-j);
         m_in[j+1] = (m_ff[j] >= sub) ? m_ff[j] - sub : m_ff[j];
      end
   end

   always_comb begin
      a0      = $signed(m_ff[MODK][ZW-1:0]);
      a1      = (a0 > PI_ANG) ? a0 - M_ANG : a0;
      a_in    = a1;
      flip_in = 1'b0;
      if (a1 > HALF_ANG) begin
         a_in    = a1 - PI_ANG;
         flip_in = 1'b1;
      end else if (a1 < -HALF_ANG) begin
         a_in    = a1 + PI_ANG;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         for (int j = 0; j <= MODK; j++) vld_ff[j] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         va_ff     <= in_vld;
         vb_ff     <= va_ff;
         vld_ff[0] <= vb_ff;
         for (int j = 0; j < MODK; j++) vld_ff[j+1] <= vld_ff[j];
         vo_ff <= vld_ff[MODK];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= PRW'(progress) * PRW'(in_ratio);
         ra_ff     <= in_r;
         za_ff     <= in_z;
         bigb_ff   <= big_in;
         twb_ff    <= tw_in;
         zb_ff     <= za_ff;
         m_ff[0]   <= sum_in;
         big_ff[0] <= bigb_ff;
         for (int j = 0; j < MODK; j++) begin
            m_ff[j+1]   <= m_in[j+1];
            big_ff[j+1] <= big_ff[j];
         end
         a_ff    <= a_in;
         flip_ff <= flip_in;
         bo_ff   <= big_ff[MODK];
      end
   end

   assign out_vld   = vo_ff;
   assign out_big_r = bo_ff;
   assign out_angle = a_ff;
   assign out_flip  = flip_ff;

endmodule

`default_nettype wire

FILE: src/swt_cordic_rot.sv
// Rotation CORDIC pipeline: turns (R, 0) by the wrapped angle and removes the gain.
`default_nettype none

module swt_cordic_rot #(
   parameter int STEPS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_vld,
   input  swt_pkg::big_type    in_big_r,
   input  swt_pkg::ang_type    in_angle,
   input  logic                in_flip,
   output logic                out_vld,
   output swt_pkg::coord_type  out_x,
   output swt_pkg::coord_type  out_y,
   output logic                out_flip
);
   import swt_pkg::*;

   localparam int PW = RVW + 17;

   logic signed [RVW-1:0] vx_ff [1:STEPS];
   logic signed [RVW-1:0] vy_ff [1:STEPS];
   ang_type               a_ff  [1:STEPS];
   logic                  f_ff  [1:STEPS];
   logic                  vld_ff [1:STEPS];
   // stage views, stage 0 being the input itself
   logic signed [RVW-1:0] vx_s  [0:STEPS-1];
   logic signed [RVW-1:0] vy_s  [0:STEPS-1];
   ang_type               a_s   [0:STEPS-1];
   logic                  f_s   [0:STEPS-1];
   logic                  vld_s [0:STEPS-1];
   logic signed [RVW-1:0] vx_in [1:STEPS];
   logic signed [RVW-1:0] vy_in [1:STEPS];
   ang_type               a_in  [1:STEPS];

   logic signed [PW-1:0]  px, py;
   coord_type             ox_ff, oy_ff;
   logic                  fo_ff, vo_ff;

   always_comb begin
      vx_s[0]  = $signed(RVW'(in_big_r));
      vy_s[0]  = '0;
      a_s[0]   = in_angle;
      f_s[0]   = in_flip;
      vld_s[0] = in_vld;
      for (int k = 1; k < STEPS; k++) begin
         vx_s[k]  = vx_ff[k];
         vy_s[k]  = vy_ff[k];
         a_s[k]   = a_ff[k];
         f_s[k]   = f_ff[k];
         vld_s[k] = vld_ff[k];
      end
   end

   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         if (!a_s[k][ZW-1]) begin
            vx_in[k+1] = vx_s[k] - (vy_s[k] >>> k);
            vy_in[k+1] = vy_s[k] + (vx_s[k] >>> k);
            a_in[k+1]  = a_s[k] - atan_entry(k);
         end else begin
            vx_in[k+1] = vx_s[k] + (vy_s[k] >>> k);
            vy_in[k+1] = vy_s[k] - (vx_s[k] >>> k);
            a_in[k+1]  = a_s[k] + atan_entry(k);
         end
      end
   end

   always_comb begin
      px = PW'(vx_ff[STEPS]) * PW'(INVK_Q16);
      py = PW'(vy_ff[STEPS]) * PW'(INVK_Q16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= STEPS; k++) vld_ff[k] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < STEPS; k++) vld_ff[k+1] <= vld_s[k];
         vo_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STEPS; k++) begin
            vx_ff[k+1] <= vx_in[k+1];
            vy_ff[k+1] <= vy_in[k+1];
            a_ff[k+1]  <= a_in[k+1];
            f_ff[k+1]  <= f_s[k];
         end
         ox_ff <= OW'(px >>> 16);
         oy_ff <= OW'(py >>> 16);
         fo_ff <= f_ff[STEPS];
      end
   end

   assign out_vld  = vo_ff;
   assign out_x    = ox_ff;
   assign out_y    = oy_ff;
   assign out_flip = fo_ff;

endmodule

`default_nettype wire
